@@ hw/rtl/weighted_five_tap_amplitude_filter_defines.svh @@
// ----------------------------------------------------------------------------
// weighted_five_tap_amplitude_filter_defines.svh
// Assertion macros used by the filter top module. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_FIVE_TAP_AMPLITUDE_FILTER_DEFINES_SVH
`define WEIGHTED_FIVE_TAP_AMPLITUDE_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, ignored while reset is asserted.
`define WFAF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wfaf assertion failed");
// Checked property, also evaluated during reset.
`define WFAF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("wfaf assertion failed");
`else
`define WFAF_ASSERT(label, clk, rst_n, prop)
`define WFAF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ hw/rtl/wfaf_pkg.sv @@
// ----------------------------------------------------------------------------
// wfaf_pkg
// Constants and types for the weighted five-tap amplitude filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wfaf_pkg;

    localparam int SAMPLE_W     = 18;
    localparam int WEIGHT_W     = 7;
    localparam int AMP_W        = 18;
    localparam int TAP_COUNT    = 5;
    localparam int WEIGHT_SHIFT = 6;

    localparam int AMP_MAX = (2 ** AMP_W) - 1;

    // signed weight times zero-extended sample
    localparam int PROD_W = SAMPLE_W + 1 + WEIGHT_W;
    // product after the arithmetic right shift
    localparam int TERM_W = PROD_W - WEIGHT_SHIFT;
    localparam int SUM_W  = TERM_W + $clog2(TAP_COUNT);
    localparam int CMP_W  = (SUM_W > AMP_W + 1) ? SUM_W : AMP_W + 1;
    localparam int FILL_W = $clog2(TAP_COUNT + 1);

    localparam int S_TDATA_W = ((SAMPLE_W + WEIGHT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((AMP_W + 7) / 8) * 8;

    typedef logic        [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic        [AMP_W-1:0]    amp_t;
    typedef logic signed [TERM_W-1:0]   term_t;
    typedef logic        [FILL_W-1:0]   fill_t;

    // control carried alongside the window into the datapath
    typedef struct packed {
        logic valid;
        logic full;
        logic flag;
    } wfaf_ctrl_t;

    typedef struct packed {
        logic valid;
        amp_t amplitude;
        logic flag;
    } wfaf_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/wfaf_mac.sv @@
// ----------------------------------------------------------------------------
// wfaf_mac
// Weighted sum datapath: per-tap products registered, then sum, clamp and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wfaf_mac
    import wfaf_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         adv,
    input  wire wfaf_ctrl_t   ctrl_in,
    input  wire sample_t      samp_win [TAP_COUNT],
    input  wire weight_t      wt_win   [TAP_COUNT],
    output wfaf_result_t      result
);

    logic signed [PROD_W-1:0] prod [TAP_COUNT];
    term_t                    term_next [TAP_COUNT];
    term_t                    term_reg  [TAP_COUNT];
    wfaf_ctrl_t               ctrl_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [CMP_W-1:0]  sum_ext;
    amp_t                     amp_next;
    wfaf_result_t             result_reg;

    // floor(w*s / 2^shift) is the upper part of the two's complement product
    always_comb begin
        for (int k = 0; k < TAP_COUNT; k++) begin
            prod[k]      = wt_win[k] * $signed({1'b0, samp_win[k]});
            term_next[k] = prod[k][PROD_W-1:WEIGHT_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            term_reg <= term_next;
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < TAP_COUNT; k++) begin
            sum = sum + SUM_W'(term_reg[k]);
        end
        sum_ext = CMP_W'(sum);
        if (sum_ext < 0) begin
            amp_next = '0;
        end else if (sum_ext > $signed(CMP_W'(AMP_MAX))) begin
            amp_next = AMP_W'(AMP_MAX);
        end else begin
            amp_next = sum_ext[AMP_W-1:0];
        end
    end

    // data fields load on advance; only the valid bits take the reset
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctrl_reg.full        <= ctrl_in.full;
            ctrl_reg.flag        <= ctrl_in.flag;
            result_reg.amplitude <= ctrl_reg.full ? amp_next : '0;
            result_reg.flag      <= ctrl_reg.full & ctrl_reg.flag;
        end
        if (!aresetn) begin
            ctrl_reg.valid   <= 1'b0;
            result_reg.valid <= 1'b0;
        end else if (adv) begin
            ctrl_reg.valid   <= ctrl_in.valid;
            result_reg.valid <= ctrl_reg.valid;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

@@ hw/rtl/weighted_five_tap_amplitude_filter.sv @@
// ----------------------------------------------------------------------------
// weighted_five_tap_amplitude_filter
// Five-tap FIR where every sample brings its own signed weight. Output is
// the clamped sum of floor(weight*sample/64) over the last five samples.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Contents (low bit first)
//  --------+--------------------------------+----------------------------------
//  input   | s_tvalid s_tready s_tdata      | tdata: sample[17:0],
//          | s_tuser                        |   tap_weight[24:18]; tuser:
//          |                                |   flag_in[0], frame_start[1]
//  result  | m_tvalid m_tready m_tdata      | tdata: amplitude[17:0];
//          | m_tuser                        |   tuser: flag_out[0]
//
//  One transaction in, one transaction out, one per clock sustained while
//  m_tready stays high. The pipe is the window register, the product
//  registers (five multipliers), then sum/clamp into the result register.
//  The whole pipe advances together; it stalls only while a result sits
//  unaccepted on the master side, so s_tready is !m_tvalid || m_tready.
//  Synchronous active-low reset clears the fill count and valid bits; the
//  window contents are not reset since each frame refills them before use.
//  The first five transactions of a frame (after reset or frame_start)
//  return amplitude 0 and flag 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weighted_five_tap_amplitude_filter_defines.svh"

module weighted_five_tap_amplitude_filter
    import wfaf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // sample[17:0], tap_weight[24:18]
    input  wire logic [1:0]           s_tuser,   // flag_in[0], frame_start[1]
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // amplitude[17:0]
    output logic [0:0]                m_tuser    // flag_out[0]
);

    // input field unpacking
    sample_t      in_sample;
    weight_t      in_weight;
    logic         in_flag;
    logic         in_start;

    // pipe control
    logic         adv;
    logic         accept;

    // window, index 0 is the oldest entry
    sample_t      samp_win_reg [TAP_COUNT];
    weight_t      wt_win_reg   [TAP_COUNT];
    logic         flag_win_reg [TAP_COUNT];

    // fill tracking
    fill_t        fill_cnt_reg;
    fill_t        fill_cnt_next;
    fill_t        fill_eff;
    logic         win_full;

    wfaf_ctrl_t   ctrl_reg;
    wfaf_result_t result;

    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_weight = s_tdata[SAMPLE_W+WEIGHT_W-1:SAMPLE_W];
    assign in_flag   = s_tuser[0];
    assign in_start  = s_tuser[1];

    // every stage moves when the result register is empty or being drained
    assign adv      = !result.valid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // frame_start restarts the fill before this transaction is counted;
    // the window is full only if five entries were already filled
    always_comb begin
        fill_eff = in_start ? '0 : fill_cnt_reg;
        win_full = (fill_eff == FILL_W'(TAP_COUNT));
        fill_cnt_next = win_full ? fill_eff : fill_eff + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
        end else if (accept) begin
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    // Plain shift line: filling in order from entry 0 and shifting once full
    // leave the same contents once five entries are in.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < TAP_COUNT - 1; k++) begin
                samp_win_reg[k] <= samp_win_reg[k+1];
                wt_win_reg[k]   <= wt_win_reg[k+1];
                flag_win_reg[k] <= flag_win_reg[k+1];
            end
            samp_win_reg[TAP_COUNT-1] <= in_sample;
            wt_win_reg[TAP_COUNT-1]   <= in_weight;
            flag_win_reg[TAP_COUNT-1] <= in_flag;
            ctrl_reg.full             <= win_full;
            // flag of the transaction before this one
            ctrl_reg.flag             <= flag_win_reg[TAP_COUNT-1];
        end
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (adv) begin
            ctrl_reg.valid <= accept;
        end
    end

    wfaf_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .ctrl_in  (ctrl_reg),
        .samp_win (samp_win_reg),
        .wt_win   (wt_win_reg),
        .result   (result)
    );

    assign m_tvalid = result.valid;
    assign m_tdata  = M_TDATA_W'(result.amplitude);
    assign m_tuser  = result.flag;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `WFAF_ASSERT(a_ready_follows_out, aclk, aresetn, s_tready == (!m_tvalid || m_tready))
    `WFAF_ASSERT(a_start_refills, aclk, aresetn, accept && in_start |=> fill_cnt_reg == 1)
    `WFAF_ASSERT(a_fill_counts, aclk, aresetn, accept && !in_start && fill_cnt_reg < FILL_W'(TAP_COUNT) |=> fill_cnt_reg == FILL_W'($past(fill_cnt_reg) + 1'b1))
    `WFAF_ASSERT(a_fill_saturates, aclk, aresetn, accept && !in_start && fill_cnt_reg == FILL_W'(TAP_COUNT) |=> fill_cnt_reg == FILL_W'(TAP_COUNT))

endmodule

`default_nettype wire
